FILE: rtl/bpar_pkg.sv
// Shared types, constants and AES round functions for the private address resolver.
package bpar_pkg;

   localparam logic [7:0] TYPE_MASK       = 8'hC0;
   localparam logic [7:0] TYPE_RESOLVABLE = 8'h40;
   localparam int         KEY_BITS        = 128;
   localparam int         AES_ROUNDS      = 10;
   localparam logic [1:0] VARIANT_FIRST   = 2'd0;
   localparam logic [1:0] VARIANT_LAST    = 2'd3;

   localparam logic CSR_KEY_UPPER = 1'b0;
   localparam logic CSR_KEY_LOWER = 1'b1;

   localparam logic [7:0] RCON_TABLE [AES_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   typedef struct packed {
      logic [47:0] address;
      logic        resolvable;
   } entry_type;

   typedef struct packed {
      logic                valid;
      logic [1:0]          variant;
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] block;
      entry_type           entry;
   } aes_issue_type;

   typedef struct packed {
      logic                valid;
      logic [1:0]          variant;
      logic [KEY_BITS-1:0] state;
      logic [KEY_BITS-1:0] rkey;
      entry_type           entry;
   } aes_stage_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] variant;
      logic [23:0] hash;
      entry_type  entry;
   } aes_result_type;

   typedef struct packed {
      logic       resolvable;
      logic [3:0] match_mask;
      logic       found;
      logic [1:0] first_variant;
   } rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic logic [KEY_BITS-1:0] sub_shift(input logic [KEY_BITS-1:0] s);
      logic [KEY_BITS-1:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[127-8*(i+4*c) -: 8] = sbox(s[127-8*(i+4*((c+i)%4)) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [KEY_BITS-1:0] mix_columns(input logic [KEY_BITS-1:0] s);
      logic [KEY_BITS-1:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127-32*c -: 8];
         a1  = s[119-32*c -: 8];
         a2  = s[111-32*c -: 8];
         a3  = s[103-32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic logic [KEY_BITS-1:0] next_rkey(input logic [KEY_BITS-1:0] rk,
                                                     input logic [7:0] rcon);
      logic [31:0] temp, n0, n1, n2, n3;
      temp = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
      n0   = rk[127:96] ^ temp;
      n1   = rk[95:64] ^ n0;
      n2   = rk[63:32] ^ n1;
      n3   = rk[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

FILE: rtl/bpar_front.sv
// Front end: accepts addresses, tags the resolvable type and queues them for the back end.
module bpar_front import bpar_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [47:0] req_address,
   output logic        full,
   output logic        head_valid,
   output entry_type   head,
   input  logic        head_pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       queue_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;
   entry_type       new_entry;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_push && !full;
   assign pop        = head_pop && head_valid;

   assign new_entry.address    = req_address;
   assign new_entry.resolvable = ((req_address[47:40] & TYPE_MASK) == TYPE_RESOLVABLE);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: rtl/bpar_aes_pipe.sv
// Fully pipelined AES-128 core, one round per stage with the key schedule alongside.
module bpar_aes_pipe import bpar_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  aes_issue_type  issue,
   output aes_result_type result
);

   aes_stage_type stage_ff [AES_ROUNDS+1];
   aes_stage_type stage_in [AES_ROUNDS+1];

   always_comb begin
      stage_in[0].valid   = issue.valid;
      stage_in[0].variant = issue.variant;
      stage_in[0].state   = issue.block ^ issue.key;
      stage_in[0].rkey    = issue.key;
      stage_in[0].entry   = issue.entry;
   end

   for (genvar r = 1; r <= AES_ROUNDS; r++) begin : g_round
      logic [KEY_BITS-1:0] rkey_new, shifted, mixed;
      assign rkey_new = next_rkey(stage_ff[r-1].rkey, RCON_TABLE[r-1]);
      assign shifted  = sub_shift(stage_ff[r-1].state);
      // final round skips the column mix
      assign mixed    = (r == AES_ROUNDS) ? shifted : mix_columns(shifted);
      always_comb begin
         stage_in[r]       = stage_ff[r-1];
         stage_in[r].state = mixed ^ rkey_new;
         stage_in[r].rkey  = rkey_new;
      end
   end

   for (genvar k = 0; k <= AES_ROUNDS; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign result.valid   = stage_ff[AES_ROUNDS].valid;
   assign result.variant = stage_ff[AES_ROUNDS].variant;
   assign result.hash    = stage_ff[AES_ROUNDS].state[23:0];
   assign result.entry   = stage_ff[AES_ROUNDS].entry;

endmodule

FILE: rtl/bpar_back.sv
// Back end: issues four variants per address, collects the hash compares, queues results.
module bpar_back import bpar_pkg::*; #(
   parameter int RSP_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_BITS-1:0] key,
   input  logic                head_valid,
   input  entry_type           head,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_word
);

   localparam int PW = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CW = $clog2(RSP_DEPTH + 1);

   logic [1:0]          variant_ff, variant_in;
   logic [CW-1:0]       credit_ff, credit_in;
   logic                issue_go;
   logic [KEY_BITS-1:0] key_rev;
   logic [23:0]         rand_part;
   aes_issue_type       issue;
   aes_result_type      result;

   logic [3:0]          mask_ff, mask_in;
   logic [3:0]          mask_now;
   rsp_type             rsp_new;
   logic                rsp_push, rsp_take;

   rsp_type             rsp_ff [RSP_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;

   // a result slot is reserved when an address starts, so the pipe never stalls
   assign issue_go = head_valid &&
                     ((variant_ff != VARIANT_FIRST) || (credit_ff < CW'(RSP_DEPTH)));
   assign head_pop = issue_go && (variant_ff == VARIANT_LAST);
   assign variant_in = issue_go ? variant_ff + 1'b1 : variant_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         key_rev[127-8*i -: 8] = key[8*i+7 -: 8];
      end
   end

   assign rand_part = variant_ff[1] ?
                      {head.address[31:24], head.address[39:32], head.address[47:40]} :
                      head.address[47:24];

   assign issue.valid   = issue_go;
   assign issue.variant = variant_ff;
   assign issue.key     = variant_ff[0] ? key_rev : key;
   assign issue.block   = {104'd0, rand_part};
   assign issue.entry   = head;

   bpar_aes_pipe u_aes (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .result (result)
   );

   // collect the four compares of one address
   always_comb begin
      mask_now = (result.variant == VARIANT_FIRST) ? 4'd0 : mask_ff;
      mask_now[result.variant] = (result.hash == result.entry.address[23:0]);
      mask_in  = result.valid ? mask_now : mask_ff;
      rsp_new.resolvable    = result.entry.resolvable;
      rsp_new.match_mask    = result.entry.resolvable ? mask_now : 4'd0;
      rsp_new.found         = (rsp_new.match_mask != 4'd0);
      rsp_new.first_variant = rsp_new.match_mask[0] ? 2'd0 :
                              rsp_new.match_mask[1] ? 2'd1 :
                              rsp_new.match_mask[2] ? 2'd2 :
                              rsp_new.match_mask[3] ? 2'd3 : 2'd0;
   end

   assign rsp_push  = result.valid && (result.variant == VARIANT_LAST);
   assign rsp_empty = (count_ff == '0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_word  = rsp_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      credit_in = credit_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rsp_take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push && !rsp_take) begin
         count_in = count_ff + 1'b1;
      end else if (rsp_take && !rsp_push) begin
         count_in = count_ff - 1'b1;
      end
      if ((issue_go && (variant_ff == VARIANT_FIRST)) && !rsp_take) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_take && !(issue_go && (variant_ff == VARIANT_FIRST))) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VARIANT_FIRST;
         credit_ff  <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         mask_ff    <= '0;
      end else begin
         variant_ff <= variant_in;
         credit_ff  <= credit_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         mask_ff    <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

FILE: rtl/ble_private_address_resolver.sv
// Top level of the BLE private address resolver.
// An accepted address passes the request queue, the AES core and the result queue.
// Each takes four passes through the single pipelined AES-128 core (11 register
// stages deep), one pass per cycle once it holds a result slot; addresses overlap.
// Reset: synchronous, clears both queues, the issue sequencer and the key registers.
module ble_private_address_resolver import bpar_pkg::*; #(
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [47:0] req_address,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_is_resolvable_type,
   output logic [3:0]  rsp_match_mask,
   output logic        rsp_found,
   output logic [1:0]  rsp_first_variant,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] key_upper_ff, key_upper_in, key_lower_ff, key_lower_in;
   logic        head_valid, head_pop;
   entry_type   head;
   rsp_type     rsp_word;

   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_UPPER: key_upper_in = csr_write_data;
            CSR_KEY_LOWER: key_lower_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else begin
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
      end
   end

   bpar_front #(.DEPTH(REQ_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_address (req_address),
      .full        (full),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   bpar_back #(.RSP_DEPTH(RSP_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .key        ({key_upper_ff, key_lower_ff}),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_word   (rsp_word)
   );

   assign rsp_is_resolvable_type = rsp_word.resolvable;
   assign rsp_match_mask         = rsp_word.match_mask;
   assign rsp_found              = rsp_word.found;
   assign rsp_first_variant      = rsp_word.first_variant;

endmodule

FILE: rtl/bpar_checker.sv
// Port-level checks on the resolver's result words, bound to the top level.
module bpar_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic [47:0] req_address,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic        rsp_is_resolvable_type,
   input logic [3:0]  rsp_match_mask,
   input logic        rsp_found,
   input logic [1:0]  rsp_first_variant,
   input logic        csr_write_enable,
   input logic        csr_index,
   input logic [63:0] csr_write_data
);

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_match_mask) && $stable(rsp_found)))
      else $error("result word changed while waiting");

   a_found_mask: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_found == (rsp_match_mask != 4'd0)))
      else $error("found disagrees with match mask");

   a_not_resolvable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_is_resolvable_type) |-> (rsp_match_mask == 4'd0))
      else $error("match on an address that is not resolvable");

   a_first_lowest: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_found) |-> rsp_match_mask[rsp_first_variant] &&
         ((rsp_match_mask & ((4'd1 << rsp_first_variant) - 4'd1)) == 4'd0))
      else $error("first variant is not the lowest match");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

endmodule

bind ble_private_address_resolver bpar_checker u_checker (.*);

FILE: test/ble_rpa_checker.sv
// Checker for the private address resolver: watches both queues, predicts and compares.
module ble_rpa_checker import bpar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [47:0] req_address,
   input  logic        full,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_is_resolvable_type,
   input  logic [3:0]  rsp_match_mask,
   input  logic        rsp_found,
   input  logic [1:0]  rsp_first_variant,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data,
   output int          mismatches,
   output int          pending,
   output int          words_checked,
   output int          words_found
);

   logic [7:0]  sbox_lut [256];
   logic [63:0] key_hi, key_lo;
   rsp_type     expected_words [$];

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // S-box built from the field inverse plus the affine map
   initial begin
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                       {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   end

   function automatic logic [7:0] dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block sits at bits 127-8i downto 120-8i
   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] pt);
      logic [7:0]   k [16];
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   w [4];
      logic [7:0]   rc, a0, a1, a2, a3, all;
      logic [127:0] ct;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         k[i] = key[127-8*i -: 8];
         s[i] = pt[127-8*i -: 8] ^ k[i];
      end
      for (int r = 1; r <= 10; r++) begin
         w[0] = sbox_lut[k[13]] ^ rc;
         w[1] = sbox_lut[k[14]];
         w[2] = sbox_lut[k[15]];
         w[3] = sbox_lut[k[12]];
         for (int i = 0; i < 16; i++)
            k[i] = k[i] ^ ((i < 4) ? w[i] : k[i-4]);
         rc = dbl(rc);
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[i+4*c] = sbox_lut[s[i+4*((c+i)%4)]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
      end
      for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
      return ct;
   endfunction

   // variant bit 0: key byte-reversed, bit 1: random part byte-reversed
   function automatic logic [23:0] rpa_hash(input logic [127:0] key,
                                            input logic [23:0] prand,
                                            input logic [1:0] variant);
      logic [127:0] k, ct;
      logic [23:0]  r;
      k  = variant[0] ? {<<8{key}} : key;
      r  = variant[1] ? {prand[7:0], prand[15:8], prand[23:16]} : prand;
      ct = aes_encrypt(k, {104'd0, r});
      return ct[23:0];
   endfunction

   function automatic rsp_type resolve(input logic [47:0] a);
      rsp_type w;
      w = '0;
      w.resolvable = (a[47:40] & TYPE_MASK) == TYPE_RESOLVABLE;
      if (w.resolvable) begin
         for (int v = 3; v >= 0; v--) begin
            if (rpa_hash({key_hi, key_lo}, a[47:24], v[1:0]) == a[23:0]) begin
               w.match_mask[v] = 1'b1;
               w.first_variant = v[1:0];
            end
         end
      end
      w.found = |w.match_mask;
      return w;
   endfunction

   assign pending = expected_words.size();

   always @(posedge clock) begin
      rsp_type got, exp_w;
      if (reset) begin
         key_hi <= '0;
         key_lo <= '0;
         expected_words.delete();
         mismatches    = 0;
         words_checked = 0;
         words_found   = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_KEY_UPPER) key_hi <= csr_write_data;
            else                            key_lo <= csr_write_data;
         end
         if (req_push && !full) expected_words.push_back(resolve(req_address));
         if (pop && !empty) begin
            got = '{rsp_is_resolvable_type, rsp_match_mask, rsp_found, rsp_first_variant};
            words_checked++;
            if (got.found) words_found++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp word %p", got);
            end else begin
               exp_w = expected_words.pop_front();
               if (got !== exp_w) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp word mismatch: expected %p got %p", exp_w, got);
               end
            end
         end
      end
   end

endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for the private address resolver.
module tb_top import bpar_pkg::*;;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_RANDOM  = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [47:0] req_address = '0;
   logic        full, empty;
   logic        pop = 1'b0;
   logic        rsp_is_resolvable_type, rsp_found;
   logic [3:0]  rsp_match_mask;
   logic [1:0]  rsp_first_variant;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_KEY_UPPER;
   logic [63:0] csr_write_data = '0;

   int          mismatches, pending, words_checked, words_found;
   int          cycles = 0;
   int          key_settings = 1;
   bit          idling = 1'b1;
   logic [63:0] cur_hi = '0, cur_lo = '0;

   always #5 clock = ~clock;

   ble_private_address_resolver i_dut (.*);

   ble_rpa_checker i_checker (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stall bursts while idling is set
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            pop = 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(0, 5);
            pop = 1'b0;
         end else begin
            pop = 1'b1;
         end
      end
   end

   task automatic send_word(input logic [47:0] a);
      logic was_full;
      if (idling && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 6)) @(negedge clock);
      req_push    = 1'b1;
      req_address = a;
      do begin
         was_full = full;  // stable until the next rising edge
         @(negedge clock);
      end while (was_full);
      req_push = 1'b0;
   endtask

   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      wait (pending == 0);
      repeat (20) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = CSR_KEY_UPPER;
      csr_write_data   = hi;
      @(negedge clock);
      csr_index        = CSR_KEY_LOWER;
      csr_write_data   = lo;
      @(negedge clock);
      csr_write_enable = 1'b0;
      cur_hi = hi;
      cur_lo = lo;
      key_settings++;
   endtask

   // address whose hash matches the given variant under the current key
   function automatic logic [47:0] matching(input logic [23:0] prand, input logic [1:0] v);
      return {prand, i_checker.rpa_hash({cur_hi, cur_lo}, prand, v)};
   endfunction

   task automatic random_words(input int n);
      logic [23:0] prand;
      logic [47:0] a;
      for (int i = 0; i < n; i++) begin
         prand = {2'b01, 22'($urandom)};
         case ($urandom_range(0, 9))
            0, 1:    a = {16'($urandom), 32'($urandom)};
            2:       a = matching(prand, 2'($urandom)) ^ (48'd1 << $urandom_range(0, 23));
            3:       a = {prand, 24'($urandom)};
            default: a = matching(prand, 2'($urandom));
         endcase
         send_word(a);
      end
   endtask

   initial begin
      logic [63:0] r;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, each address type, each variant, no match
      send_word('0);
      send_word('1);
      send_word(48'h4000_0000_0000);
      send_word(48'h7FFF_FFFF_FFFF);
      send_word(48'h8000_0000_0000);
      send_word(48'hC0FF_EE12_3456);
      send_word(48'h3FFF_FFFF_FFFF);
      for (int v = 0; v < 4; v++) send_word(matching(24'h5A_C3_17, v[1:0]));
      send_word(matching(24'h40_00_00, 2'd0));
      send_word(matching(24'h7F_FF_FF, 2'd3));
      send_word(matching(24'h42_99_42, 2'd2));  // symmetric random part: 0 and 2 agree
      random_words(NUM_RANDOM);

      write_key('1, '1);
      for (int v = 0; v < 4; v++) send_word(matching(24'h61_0F_3C, v[1:0]));
      random_words(NUM_RANDOM);

      write_key('0, '1);
      random_words(NUM_RANDOM);

      // byte-symmetric key: key-reversed variants coincide with the plain ones
      r = {$urandom, $urandom};
      write_key(r, {<<8{r}});
      send_word(matching(24'h55_AA_55, 2'd0));
      random_words(NUM_RANDOM);

      write_key({$urandom, $urandom}, {$urandom, $urandom});
      random_words(NUM_RANDOM);

      write_key({$urandom, $urandom}, {$urandom, $urandom});
      idling = 1'b0;
      random_words(NUM_RANDOM);

      wait (pending == 0);
      repeat (40) @(negedge clock);
      $display("checked %0d result words under %0d key settings, %0d with a hash match",
               words_checked, key_settings, words_found);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bpar_pkg.sv
rtl/bpar_front.sv
rtl/bpar_aes_pipe.sv
rtl/bpar_back.sv
rtl/ble_private_address_resolver.sv
rtl/bpar_checker.sv
test/ble_rpa_checker.sv
test/tb_top.sv
